### design/mf3_pkg.sv
// Package for the 3x3 median filter: widths, register map, reset values and the
// nine-input median network. Used by the interfaces, the top level and the checker.
package mf3_pkg;

  localparam int PixelW       = 8;
  localparam int ImageWidthW  = 12;
  localparam int ImageHeightW = 13;
  localparam int RowW         = 12;
  localparam int MaxWidthDef  = 2048;
  localparam int HeightMax    = 4096;
  localparam int MinDim       = 3;
  localparam int WidthReset   = 640;
  localparam int HeightReset  = 480;
  localparam int WinTaps      = 9;
  localparam int WinCells     = 6;

  // APB register map: one 32-bit word per register, index taken from paddr[2].
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam logic RegImageWidth  = 1'b0;
  localparam logic RegImageHeight = 1'b1;

  typedef logic [PixelW-1:0] pixel_t;

  // Compare-exchange: returns {smaller, larger}.
  function automatic logic [2*PixelW-1:0] sort2(input pixel_t a, input pixel_t b);
    return (a > b) ? {b, a} : {a, b};
  endfunction

  // Nineteen compare-exchange steps that leave the median of nine in the middle slot.
  function automatic pixel_t median9(input pixel_t v [WinTaps]);
    pixel_t p [WinTaps];
    p = v;
    {p[1], p[2]} = sort2(p[1], p[2]);
    {p[4], p[5]} = sort2(p[4], p[5]);
    {p[7], p[8]} = sort2(p[7], p[8]);
    {p[0], p[1]} = sort2(p[0], p[1]);
    {p[3], p[4]} = sort2(p[3], p[4]);
    {p[6], p[7]} = sort2(p[6], p[7]);
    {p[1], p[2]} = sort2(p[1], p[2]);
    {p[4], p[5]} = sort2(p[4], p[5]);
    {p[7], p[8]} = sort2(p[7], p[8]);
    {p[0], p[3]} = sort2(p[0], p[3]);
    {p[5], p[8]} = sort2(p[5], p[8]);
    {p[4], p[7]} = sort2(p[4], p[7]);
    {p[3], p[6]} = sort2(p[3], p[6]);
    {p[1], p[4]} = sort2(p[1], p[4]);
    {p[2], p[5]} = sort2(p[2], p[5]);
    {p[4], p[7]} = sort2(p[4], p[7]);
    {p[4], p[2]} = sort2(p[4], p[2]);
    {p[6], p[4]} = sort2(p[6], p[4]);
    {p[4], p[2]} = sort2(p[4], p[2]);
    return p[4];
  endfunction

endpackage

### design/mf3_if.sv
// Stream interfaces of the 3x3 median filter: pixel input and median result.
// Depends on mf3_pkg for the pixel type.
interface mf3_pix_if;
  import mf3_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t pixel_in;
  logic   frame_start;
  modport source (output valid, output pixel_in, output frame_start, input ready);
  modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface mf3_med_if;
  import mf3_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t pixel_out;
  logic   row_end;
  logic   frame_end;
  modport source (output valid, output pixel_out, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input pixel_out, input row_end, input frame_end,
                  output ready);
endinterface

### design/mf3_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies; contents are undefined until written.
module mf3_ram #(
  parameter int Width = 16,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data is registered, appears in the cycle after the enable and holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/median_filter_3x3.sv
// 3x3 median filter over a raster stream of 8-bit pixels. One pixel is taken per clock
// unless results stall; results pass stage 1 and the output register. Only interior
// positions produce a result, in raster order, with row_end on the last of each row and
// frame_end on the last of the frame; frame_start restarts the row and column counters.
// The two rows above share one line RAM of MAX_WIDTH words (upper and lower pixel side
// by side), read and written once per pixel, so its single read and write ports set the
// rate. Geometry must be written over APB only while idle; the block does not check it.
module median_filter_3x3 #(
  parameter int MAX_WIDTH = mf3_pkg::MaxWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mf3_pkg::ApbAddrW-1:0]  paddr,
  input  logic [mf3_pkg::ApbDataW-1:0]  pwdata,
  output logic [mf3_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  mf3_pix_if.sink                       in_if,
  mf3_med_if.source                     out_if
);
  import mf3_pkg::*;

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int CmpW = ($clog2(MAX_WIDTH + 1) > ImageWidthW) ?
                        $clog2(MAX_WIDTH + 1) : ImageWidthW;

  // Configuration registers.
  logic [ImageWidthW-1:0]  width_q;
  logic [ImageHeightW-1:0] height_q;
  logic                    cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ImageWidthW'(WidthReset);
      height_q <= ImageHeightW'(HeightReset);
    end else if (cfg_write) begin
      unique case (paddr[2])
        RegImageWidth:  width_q  <= pwdata[ImageWidthW-1:0];
        RegImageHeight: height_q <= pwdata[ImageHeightW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegImageWidth:  prdata = ApbDataW'(width_q);
      RegImageHeight: prdata = ApbDataW'(height_q);
      default:        prdata = '0;
    endcase
  end

  // Effective geometry, saturated to the supported range.
  logic [CmpW-1:0]         width_eff;
  logic [ImageHeightW-1:0] height_eff;

  always_comb begin
    if (CmpW'(width_q) < CmpW'(MinDim)) begin
      width_eff = CmpW'(MinDim);
    end else if (CmpW'(width_q) > CmpW'(MAX_WIDTH)) begin
      width_eff = CmpW'(MAX_WIDTH);
    end else begin
      width_eff = CmpW'(width_q);
    end
    if (height_q < ImageHeightW'(MinDim)) begin
      height_eff = ImageHeightW'(MinDim);
    end else if (height_q > ImageHeightW'(HeightMax)) begin
      height_eff = ImageHeightW'(HeightMax);
    end else begin
      height_eff = height_q;
    end
  end

  // Pipeline handshake: stage 1 holds the accepted pixel while its line data is read.
  logic s1_valid_q, s1_emit_q, s1_adv, accept;
  logic out_valid_q;

  assign s1_adv      = s1_valid_q && (!s1_emit_q || !out_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || s1_adv;
  assign accept      = in_if.valid && in_if.ready;

  // Position of the incoming pixel; frame_start forces row 0, column 0.
  logic [ColW-1:0] col_q, col_cur, col_nxt;
  logic [RowW-1:0] row_q, row_cur, row_nxt;
  logic            last_col, last_row;

  assign col_cur  = in_if.frame_start ? '0 : col_q;
  assign row_cur  = in_if.frame_start ? '0 : row_q;
  assign last_col = CmpW'(col_cur) >= (width_eff - CmpW'(1));
  assign last_row = ImageHeightW'(row_cur) >= (height_eff - ImageHeightW'(1));

  always_comb begin
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_cur + RowW'(1);
    end else begin
      col_nxt = col_cur + ColW'(1);
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_nxt;
      row_q <= row_nxt;
    end
  end

  // Line RAM: {row two above, row one above} per column.
  logic [2*PixelW-1:0] ram_rdata, ram_wdata, line_data;
  logic [2*PixelW-1:0] fwd_data_q;
  logic                fwd_hit_q;
  logic [ColW-1:0]     s1_col_q;
  pixel_t              s1_px_q, up_px, mid_px;

  mf3_ram #(
    .Width (2 * PixelW),
    .Depth (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (col_cur),
    .rdata_o (ram_rdata)
  );

  // A write in the same cycle as a read of the same column is forwarded around the RAM.
  assign line_data = fwd_hit_q ? fwd_data_q : ram_rdata;
  assign up_px     = line_data[2*PixelW-1:PixelW];
  assign mid_px    = line_data[PixelW-1:0];
  assign ram_wdata = {mid_px, s1_px_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_q <= in_if.valid;
    end
  end

  logic s1_row_end_q, s1_frame_end_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q        <= in_if.pixel_in;
      s1_col_q       <= col_cur;
      s1_emit_q      <= (row_cur >= RowW'(2)) && (col_cur >= ColW'(2));
      s1_row_end_q   <= last_col;
      s1_frame_end_q <= last_col && last_row;
      fwd_hit_q      <= s1_adv && (s1_col_q == col_cur);
      fwd_data_q     <= ram_wdata;
    end
  end

  // Window of the two previous columns, top to bottom within each column.
  pixel_t win_q [WinCells];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WinCells; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_adv) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= up_px;
      win_q[4] <= mid_px;
      win_q[5] <= s1_px_q;
    end
  end

  // Median network over the full 3x3 neighborhood.
  pixel_t taps [WinTaps];
  pixel_t median;

  always_comb begin
    for (int i = 0; i < WinCells; i++) begin
      taps[i] = win_q[i];
    end
    taps[6] = up_px;
    taps[7] = mid_px;
    taps[8] = s1_px_q;
    median  = median9(taps);
  end

  // Output register.
  logic   out_load;
  pixel_t out_px_q;
  logic   out_row_end_q, out_frame_end_q;

  assign out_load = s1_adv && s1_emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_px_q        <= median;
      out_row_end_q   <= s1_row_end_q;
      out_frame_end_q <= s1_frame_end_q;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.pixel_out = out_px_q;
  assign out_if.row_end   = out_row_end_q;
  assign out_if.frame_end = out_frame_end_q;

endmodule

### design/mf3_checker.sv
// Port-level checks for the 3x3 median filter, attached to the top level by bind.
// Depends on mf3_pkg for the pixel type.
module mf3_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input mf3_pkg::pixel_t pixel_out,
  input logic            row_end,
  input logic            frame_end
);
  import mf3_pkg::*;

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) &&
                                $stable(row_end) && $stable(frame_end))
    else $error("stalled result changed");

  // The last result of a frame also ends its row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && frame_end |-> row_end)
    else $error("frame_end without row_end");

  // With no result waiting, the input is never held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // In the cycle after reset is sampled low, no result is shown.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid)
    else $error("result valid during reset");

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .pixel_out (out_if.pixel_out),
  .row_end   (out_if.row_end),
  .frame_end (out_if.frame_end)
);

### verif/mf3_checker.sv
// Scoreboard for the 3x3 median filter: follows APB register writes and checks reads,
// predicts the median stream from the accepted pixels and compares every accepted result.
// Depends on mf3_pkg and on the stream interfaces in mf3_if.sv.
module mf3_median_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mf3_pkg::ApbAddrW-1:0]  paddr,
  input  logic [mf3_pkg::ApbDataW-1:0]  pwdata,
  input  logic [mf3_pkg::ApbDataW-1:0]  prdata,
  input  logic                          pready,
  mf3_pix_if                            pix_i,
  mf3_med_if                            med_i,
  input  logic                          done_i,
  output int unsigned                   failures_o,
  output int unsigned                   pending_o
);
  import mf3_pkg::*;

  typedef struct packed {
    pixel_t level;
    logic   row_last;
    logic   frame_last;
  } median_t;

  // Shadow copy of the geometry registers, as written.
  logic [ImageWidthW-1:0]  width_reg;
  logic [ImageHeightW-1:0] height_reg;

  // Shadow copy of the raster state.
  pixel_t      upper_row [MaxWidthDef];
  pixel_t      lower_row [MaxWidthDef];
  pixel_t      window [WinCells];
  int unsigned col_pos;
  int unsigned row_pos;

  median_t     medians_due [$];
  int unsigned failures;
  bit          closed;

  // Advances the raster by one pixel and queues the median it produces, if any.
  task automatic take_pixel(input pixel_t px, input logic sof);
    int unsigned eff_w;
    int unsigned eff_h;
    int unsigned col;
    int unsigned row;
    int          i;
    int          k;
    pixel_t      above2;
    pixel_t      above1;
    pixel_t      x;
    pixel_t      s [WinTaps];
    logic        col_last;
    logic        row_last;
    median_t     m;
    eff_w = (width_reg < MinDim) ? MinDim :
            (width_reg > MaxWidthDef) ? MaxWidthDef : width_reg;
    eff_h = (height_reg < MinDim) ? MinDim :
            (height_reg > HeightMax) ? HeightMax : height_reg;
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    col = (col_pos >= MaxWidthDef) ? MaxWidthDef - 1 : col_pos;
    row = row_pos;
    above2 = upper_row[col];
    above1 = lower_row[col];
    col_last = (col >= eff_w - 1);
    row_last = (row >= eff_h - 1);

    // Interior position: sort the nine taps in descending order, take the middle one.
    if (row >= 2 && col >= 2) begin
      for (i = 0; i < WinCells; i++) begin
        s[i] = window[i];
      end
      s[6] = above2;
      s[7] = above1;
      s[8] = px;
      for (i = 1; i < WinTaps; i++) begin
        x = s[i];
        k = i - 1;
        while (k >= 0 && s[k] < x) begin
          s[k + 1] = s[k];
          k--;
        end
        s[k + 1] = x;
      end
      m.level = s[WinTaps / 2];
      m.row_last = col_last;
      m.frame_last = col_last && row_last;
      medians_due = {medians_due, m};
    end

    // Shift the line stores and the window by one column.
    upper_row[col] = above1;
    lower_row[col] = px;
    window[0] = window[3];
    window[1] = window[4];
    window[2] = window[5];
    window[3] = above2;
    window[4] = above1;
    window[5] = px;

    if (col_last) begin
      col_pos = 0;
      row_pos = row_last ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
      row_pos = row;
    end
  endtask

  // Compares one result transaction with the oldest predicted median.
  task automatic check_median();
    median_t m;
    if (medians_due.size() == 0) begin
      $error("unexpected result: pixel_out %0d, row_end %0b, frame_end %0b",
             med_i.pixel_out, med_i.row_end, med_i.frame_end);
      failures++;
    end else begin
      m = medians_due.pop_front();
      if (med_i.pixel_out !== m.level) begin
        $error("pixel_out mismatch: expected %0d, actual %0d", m.level, med_i.pixel_out);
        failures++;
      end
      if (med_i.row_end !== m.row_last) begin
        $error("row_end mismatch: expected %0b, actual %0b", m.row_last, med_i.row_end);
        failures++;
      end
      if (med_i.frame_end !== m.frame_last) begin
        $error("frame_end mismatch: expected %0b, actual %0b", m.frame_last,
               med_i.frame_end);
        failures++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [ApbDataW-1:0] reg_value;
    if (!rst_ni) begin
      width_reg = WidthReset;
      height_reg = HeightReset;
      col_pos = 0;
      row_pos = 0;
      for (int i = 0; i < WinCells; i++) begin
        window[i] = '0;
      end
      medians_due.delete();
      failures = 0;
      closed = 1'b0;
    end else begin
      // Register access phase: track writes, check read data.
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == RegImageWidth) begin
            width_reg = pwdata[ImageWidthW-1:0];
          end else begin
            height_reg = pwdata[ImageHeightW-1:0];
          end
        end else begin
          reg_value = (paddr[2] == RegImageWidth) ? ApbDataW'(width_reg) :
                                                    ApbDataW'(height_reg);
          if (prdata !== reg_value) begin
            $error("prdata mismatch at paddr %0d: expected %0d, actual %0d",
                   paddr, reg_value, prdata);
            failures++;
          end
        end
      end

      if (med_i.valid && med_i.ready) begin
        check_median();
      end
      if (pix_i.valid && pix_i.ready) begin
        take_pixel(pix_i.pixel_in, pix_i.frame_start);
      end

      // End of run: nothing may still be outstanding.
      if (done_i && !closed) begin
        closed = 1'b1;
        if (medians_due.size() != 0) begin
          $error("%0d medians never arrived", medians_due.size());
          failures++;
        end
      end
    end
    failures_o <= failures;
    pending_o <= medians_due.size();
  end

endmodule

### verif/tb_median_filter_3x3.sv
// Top of the 3x3 median filter testbench: clock, reset, APB geometry writes, pixel
// frames with random gaps and result back-pressure, and the final verdict.
// Depends on mf3_pkg, mf3_if.sv, median_filter_3x3 and mf3_median_checker.
module tb_median_filter_3x3;
  import mf3_pkg::*;

  // Random phase; together with the directed frames the run sends about 1200 pixels.
  localparam int unsigned RandomItems = 730;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 400;
  // About 1200 pixels at their slowest, plus frame set-up and the long hold-off,
  // taken several times over.
  localparam int unsigned RunLimit    = 2_000_000;

  typedef enum logic [2:0] {
    FillNoise,
    FillFlat,
    FillSaltPepper,
    FillNarrow,
    FillRamp
  } fill_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ApbAddrW-1:0]  paddr;
  logic [ApbDataW-1:0]  pwdata;
  logic [ApbDataW-1:0]  prdata;
  logic                 pready;
  logic                 done;
  int unsigned          failures;
  int unsigned          pending;

  int unsigned cur_w;
  int unsigned cur_h;
  int unsigned items_sent;
  bit          frame_open;
  bit          src_steady;
  bit          hold_asked;
  bit          hold_done;

  mf3_pix_if pix_bus ();
  mf3_med_if med_bus ();

  median_filter_3x3 u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_if   (pix_bus),
    .out_if  (med_bus)
  );

  mf3_median_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .pix_i      (pix_bus),
    .med_i      (med_bus),
    .done_i     (done),
    .failures_o (failures),
    .pending_o  (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RunLimit);
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < MinDim) return MinDim;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic pixel_t make_pixel(input fill_e fill, input int unsigned r,
                                        input int unsigned c, input pixel_t base);
    case (fill)
      FillFlat:       return base;
      FillSaltPepper: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      FillNarrow:     return base + pixel_t'($urandom_range(0, 3));
      FillRamp:       return base + pixel_t'(r * 7 + c * 13);
      default:        return pixel_t'($urandom);
    endcase
  endfunction

  // One APB transaction: setup phase, access phase until pready, then back to idle.
  task automatic apb_access(input logic wr, input logic idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Stops offering pixels and waits until the block has drained.
  task automatic wait_idle();
    pix_bus.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Writes both geometry registers while idle and reads each one back.
  task automatic write_geometry(input logic [31:0] w_raw, input logic [31:0] h_raw);
    wait_idle();
    apb_access(1'b1, RegImageWidth, w_raw);
    apb_access(1'b0, RegImageWidth, '0);
    apb_access(1'b1, RegImageHeight, h_raw);
    apb_access(1'b0, RegImageHeight, '0);
    cur_w = clamp_dim(w_raw[ImageWidthW-1:0], MaxWidthDef);
    cur_h = clamp_dim(h_raw[ImageHeightW-1:0], HeightMax);
  endtask

  // Offers one pixel transaction after a random gap (none when steady), awaits acceptance.
  task automatic send_pixel(input pixel_t px, input logic sof);
    int unsigned gap;
    gap = src_steady ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_bus.valid <= 1'b1;
    pix_bus.pixel_in <= px;
    pix_bus.frame_start <= sof;
    do @(posedge clk); while (!pix_bus.ready);
    items_sent++;
  endtask

  // Sends a frame in raster order; a nonzero cut stops it after that many pixels.
  task automatic send_frame(input int unsigned w, input int unsigned h, input logic lead_sof,
                            input int unsigned cut, input fill_e fill);
    int unsigned total;
    pixel_t      base;
    total = (cut != 0) ? cut : w * h;
    base = pixel_t'($urandom);
    for (int unsigned i = 0; i < total; i++) begin
      send_pixel(make_pixel(fill, i / w, i % w, base), lead_sof && (i == 0));
    end
    frame_open = (cut != 0);
  endtask

  // Result side: random stalls, steady stretches and one long hold-off on request.
  initial begin
    int unsigned stall;
    int unsigned taken;
    bit          steady;
    med_bus.ready <= 1'b0;
    taken = 0;
    steady = 1'b0;
    hold_done = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (taken % 40 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      if (hold_asked && !hold_done) begin
        stall = HoldCycles;
        hold_done = 1'b1;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 8);
      end
      if (stall != 0) begin
        med_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      med_bus.ready <= 1'b1;
      do @(posedge clk); while (!med_bus.valid);
      taken++;
    end
  end

  // Stimulus and verdict.
  initial begin
    int unsigned random_base;
    int unsigned cut;
    logic [31:0] w_raw;
    logic [31:0] h_raw;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    done <= 1'b0;
    pix_bus.valid <= 1'b0;
    pix_bus.pixel_in <= '0;
    pix_bus.frame_start <= 1'b0;
    items_sent = 0;
    frame_open = 1'b0;
    src_steady = 1'b0;
    hold_asked = 1'b0;
    cur_w = WidthReset;
    cur_h = HeightReset;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values, then geometry below the minimum, which saturates to 3x3.
    apb_access(1'b0, RegImageWidth, '0);
    apb_access(1'b0, RegImageHeight, '0);
    write_geometry(32'd0, 32'd2);

    // Directed frames: a flat level, then a wrap without frame start in salt and pepper,
    // then an aborted frame restarted by frame start, then a ramp.
    send_frame(3, 3, 1'b1, 0, FillFlat);
    send_frame(3, 3, 1'b0, 0, FillSaltPepper);
    send_frame(3, 3, 1'b1, 2, FillNoise);
    send_frame(3, 3, 1'b1, 0, FillRamp);

    // Geometry shrunk mid-frame: the counters sit beyond the new last column, then
    // beyond the new last row, so the row and then the frame end early.
    write_geometry({20'hFFFFF, 12'd6}, 32'd6);
    send_frame(6, 6, 1'b1, 22, FillNoise);
    write_geometry(32'd4, 32'd6);
    send_frame(4, 6, 1'b0, 5, FillNoise);
    write_geometry(32'd4, 32'd3);
    send_frame(4, 3, 1'b0, 4, FillNoise);
    send_frame(4, 3, 1'b0, 0, FillRamp);

    // Back-pressure: the result side holds off while pixels keep coming.
    write_geometry(32'd32, 32'd8);
    hold_asked = 1'b1;
    src_steady = 1'b1;
    send_frame(32, 8, 1'b1, 0, FillNoise);

    // Random frames: mostly small geometries, some aborted, some wrapping.
    random_base = items_sent;
    while (items_sent - random_base < RandomItems) begin
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 9) == 0) begin
          w_raw = $urandom_range(0, 2);
        end else if ($urandom_range(0, 15) == 0) begin
          w_raw = $urandom_range(11, 80);
        end else begin
          w_raw = $urandom_range(3, 10);
        end
        h_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
        write_geometry(w_raw, h_raw);
        frame_open = 1'b1;
      end
      cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, cur_w * cur_h - 1) : 0;
      src_steady = ($urandom_range(0, 3) == 0);
      send_frame(cur_w, cur_h, frame_open || ($urandom_range(0, 3) != 0), cut,
                 fill_e'($urandom_range(0, 4)));
    end

    // Largest geometries, each written with one dimension above range so it saturates; only
    // the start of each frame is sent.
    write_geometry(32'd4095, 32'd3);
    send_frame(cur_w, cur_h, 1'b1, 100, FillNoise);
    write_geometry(32'd3, 32'd8191);
    send_frame(cur_w, cur_h, 1'b1, 45, FillRamp);

    wait_idle();
    done <= 1'b1;
    repeat (2) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
design/mf3_pkg.sv
design/mf3_if.sv
design/mf3_ram.sv
design/median_filter_3x3.sv
design/mf3_checker.sv
verif/mf3_checker.sv
verif/tb_median_filter_3x3.sv
